// ===== rtl/core/pwav_pkg.sv =====
`timescale 1ns / 1ps
package pwav_pkg;
   localparam int VOICES = 10;
   localparam int VIDX_BITS = 4;
   localparam int TABLE_SIZE = 1024;
   localparam int TIDX_BITS = 10;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS = 20;
   localparam int HELD_MAX = 10;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_KEY_ON = 2'd1;
   localparam logic [1:0] CMD_KEY_OFF = 2'd2;
   localparam logic [1:0] CMD_TABLE_WR = 2'd3;

   localparam logic [1:0] REG_ATTACK = 2'd0;
   localparam logic [1:0] REG_DECAY = 2'd1;
   localparam logic [1:0] REG_RELEASE = 2'd2;
   localparam logic [1:0] REG_SUSTAIN = 2'd3;

   localparam logic [1:0] AMP_DIRECT = 2'd0;
   localparam logic [1:0] AMP_ATTACK = 2'd1;
   localparam logic [1:0] AMP_DECAY = 2'd2;
   localparam logic [1:0] AMP_RELEASE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TABLE, ST_KEY_SCAN, ST_KEY_OFF, ST_TICK_SEL, ST_TICK_RD,
      ST_TICK_DIV, ST_TICK_MUL, ST_TICK_ACC, ST_DONE, ST_OUT, ST_CLEAR
   } state_type;

   typedef struct packed {
      logic                start;
      logic [36:0]         dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic [36:0] quotient;
   } div_rsp_type;
endpackage

// ===== rtl/core/pwav_div.sv =====
`timescale 1ns / 1ps
module pwav_div
   import pwav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [36:0] quo_ff, quo_in;
   logic [COUNT_BITS:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [COUNT_BITS+1:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff, quo_ff[36]} - {2'b0, den_ff};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         den_in = req.divisor;
         cnt_in = 6'd37;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[COUNT_BITS+1]) begin
            rem_in = trial[COUNT_BITS:0];
            quo_in = {quo_ff[35:0], 1'b1};
         end else begin
            rem_in = {rem_ff[COUNT_BITS-1:0], quo_ff[36]};
            quo_in = {quo_ff[35:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         busy_in = (cnt_ff != 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ===== rtl/core/polyphonic_wavetable_adsr_voices.sv =====
`timescale 1ns / 1ps
// Ten-voice wavetable synthesizer with linear ADSR envelopes.
// req_ channel: one beat per command. tdata, low bit up: phase_step[31:0],
// table_index[41:32], table_value[57:42]; tuser carries command (0 tick,
// 1 key on, 2 key off, 3 table write).
// rsp_ channel: one beat per command. tdata: sample_out[19:0],
// keys_held[23:20], note_dropped[24].
// csr_ is an APB port: attack, decay, release at 0x0/0x4/0x8, sustain at 0xC.
// One command is in flight at a time; req_tready is low while it runs.
// Key off scans every voice; key on scans until a step match stops it. A
// tick visits each voice in turn: a silent voice is skipped, one at a flat
// level is read and scaled, one on a ramp also waits on the shared 37-step
// radix-2 divider. req_tready rises together with rsp_tvalid.
// The result waits in an output register for rsp_tready; one more command
// can run meanwhile and then holds in its last step with req_tready low.
// Reset is synchronous: registers go to their defaults, voices go idle and
// held count clears, then a pass over all 1024 entries zeroes the wave table
// with req_tready low.
module polyphonic_wavetable_adsr_voices
   import pwav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // phase_step, table_index, table_value
   input  logic [1:0]  req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // sample_out, keys_held, note_dropped
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [COUNT_BITS-1:0] atk_ff, dec_ff, rel_ff;
   logic [15:0] sus_ff;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         atk_ff <= 20'd480;
         dec_ff <= 20'd4800;
         rel_ff <= 20'd4800;
         sus_ff <= 16'd32768;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_ATTACK: atk_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_DECAY: dec_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_RELEASE: rel_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_SUSTAIN: sus_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_paddr[3:2])
         REG_ATTACK: csr_prdata = {12'd0, atk_ff};
         REG_DECAY: csr_prdata = {12'd0, dec_ff};
         REG_RELEASE: csr_prdata = {12'd0, rel_ff};
         REG_SUSTAIN: csr_prdata = {16'd0, sus_ff};
         default: csr_prdata = '0;
      endcase
   end

   // wave table
   logic signed [SAMPLE_BITS-1:0] wave_mem [TABLE_SIZE];
   logic signed [SAMPLE_BITS-1:0] wrd_ff;
   logic [TIDX_BITS-1:0] raddr;
   logic [TIDX_BITS-1:0] waddr;
   logic signed [SAMPLE_BITS-1:0] wdata;
   logic [TIDX_BITS-1:0] clr_ff, clr_in;

   // voice state
   logic [VOICES-1:0] held_ff, held_in;
   logic [COUNT_BITS-1:0] al_ff [VOICES], al_in [VOICES];
   logic [COUNT_BITS-1:0] dl_ff [VOICES], dl_in [VOICES];
   logic [COUNT_BITS-1:0] rl_ff [VOICES], rl_in [VOICES];
   logic [31:0] ph_ff [VOICES], ph_in [VOICES];
   logic [31:0] st_ff [VOICES], st_in [VOICES];
   logic [3:0] hc_ff, hc_in;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [31:0] step_ff, step_in;
   logic [TIDX_BITS-1:0] tidx_ff, tidx_in;
   logic signed [SAMPLE_BITS-1:0] tval_ff, tval_in;
   logic [VIDX_BITS-1:0] v_ff, v_in;
   logic signed [4:0] pick_ff, pick_in;
   logic matched_ff, matched_in;
   logic signed [39:0] acc_ff, acc_in;
   logic [16:0] amp_ff, amp_in;
   logic [1:0] mode_ff, mode_in;
   logic signed [34:0] prod_ff, prod_in;
   logic [31:0] out_ff, out_in;
   logic drop_ff, drop_in;
   logic [19:0] samp_ff, samp_in;

   div_req_type dreq;
   div_rsp_type drsp;
   pwav_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic rsp_valid_ff, rsp_valid_in;
   logic wr_en;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = out_ff;
   assign wr_en = (state_ff == ST_TABLE) || (state_ff == ST_CLEAR);
   assign waddr = (state_ff == ST_CLEAR) ? clr_ff : tidx_ff;
   assign wdata = (state_ff == ST_CLEAR) ? '0 : tval_ff;
   assign raddr = ph_ff[v_ff][31:32-TIDX_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) wave_mem[waddr] <= wdata;
      wrd_ff <= wave_mem[raddr];
   end

   logic [COUNT_BITS-1:0] l;
   logic [36:0] q;
   logic [16:0] sus17;
   logic [35:0] lmul;
   logic signed [39:0] sum;
   logic signed [23:0] qs;

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      al_in = al_ff; dl_in = dl_ff; rl_in = rl_ff; ph_in = ph_ff; st_in = st_ff;
      hc_in = hc_ff;
      cmd_in = cmd_ff; step_in = step_ff; tidx_in = tidx_ff; tval_in = tval_ff;
      v_in = v_ff; pick_in = pick_ff; matched_in = matched_ff;
      acc_in = acc_ff; amp_in = amp_ff; mode_in = mode_ff; prod_in = prod_ff;
      out_in = out_ff; drop_in = drop_ff; samp_in = samp_ff;
      rsp_valid_in = rsp_valid_ff;
      clr_in = clr_ff;
      dreq = '{start: 1'b0, dividend: '0, divisor: '0};
      l = '0;
      sus17 = {1'b0, sus_ff};
      lmul = '0;
      q = drsp.quotient;
      sum = '0;
      qs = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in = req_tuser;
               step_in = req_tdata[31:0];
               tidx_in = req_tdata[41:32];
               tval_in = req_tdata[57:42];
               v_in = '0; pick_in = -5'sd1; matched_in = 1'b0;
               acc_in = '0; drop_in = 1'b0; samp_in = '0;
               case (req_tuser)
                  CMD_TICK: state_in = ST_TICK_SEL;
                  CMD_KEY_ON: state_in = ST_KEY_SCAN;
                  CMD_KEY_OFF: state_in = ST_KEY_OFF;
                  default: state_in = ST_TABLE;
               endcase
            end
         end
         ST_TABLE: state_in = ST_OUT;
         ST_KEY_SCAN: begin
            if (!held_ff[v_ff] && rl_ff[v_ff] == '0) pick_in = {1'b0, v_ff};
            else if (!held_ff[v_ff] && pick_ff < 0) pick_in = {1'b0, v_ff};
            if (st_ff[v_ff] == step_ff) begin
               matched_in = 1'b1;
               pick_in = {1'b0, v_ff};
               state_in = ST_DONE;
            end else if (v_ff == VIDX_BITS'(VOICES-1)) begin
               state_in = ST_DONE;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (pick_ff < 0) begin
               drop_in = 1'b1;
            end else begin
               held_in[pick_ff[3:0]] = 1'b1;
               st_in[pick_ff[3:0]] = step_ff;
               ph_in[pick_ff[3:0]] = '0;
               al_in[pick_ff[3:0]] = atk_ff;
               dl_in[pick_ff[3:0]] = dec_ff;
               rl_in[pick_ff[3:0]] = rel_ff;
               if (!matched_ff && hc_ff < 4'(HELD_MAX)) hc_in = hc_ff + 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_KEY_OFF: begin
            if (st_ff[v_ff] == step_ff) begin
               held_in[v_ff] = 1'b0;
               if (hc_ff != 0) hc_in = hc_ff - 1'b1;
            end
            if (v_ff == VIDX_BITS'(VOICES-1)) state_in = ST_OUT;
            else v_in = v_ff + 1'b1;
         end
         ST_TICK_SEL: begin
            if (!held_ff[v_ff] && rl_ff[v_ff] == '0) begin
               if (v_ff == VIDX_BITS'(VOICES-1)) state_in = ST_TICK_ACC;
               else v_in = v_ff + 1'b1;
            end else begin
               mode_in = AMP_DIRECT;
               if (held_ff[v_ff]) begin
                  if (al_ff[v_ff] != 0) begin
                     l = al_ff[v_ff];
                     al_in[v_ff] = l - 1'b1;
                     if (l >= atk_ff) amp_in = '0;
                     else begin
                        mode_in = AMP_ATTACK;
                        dreq = '{start: 1'b1,
                                 dividend: 37'(atk_ff - l) << 16,
                                 divisor: atk_ff};
                     end
                  end else if (dl_ff[v_ff] != 0) begin
                     l = dl_ff[v_ff];
                     dl_in[v_ff] = l - 1'b1;
                     if (l >= dec_ff) amp_in = 17'd65536;
                     else begin
                        mode_in = AMP_DECAY;
                        lmul = (17'd65536 - sus17) * l;
                        dreq = '{start: 1'b1, dividend: 37'(lmul), divisor: dec_ff};
                     end
                  end else amp_in = sus17;
               end else begin
                  l = rl_ff[v_ff];
                  rl_in[v_ff] = l - 1'b1;
                  if (l >= rel_ff) amp_in = sus17;
                  else begin
                     mode_in = AMP_RELEASE;
                     lmul = 36'(sus17) * l;
                     dreq = '{start: 1'b1, dividend: 37'(lmul), divisor: rel_ff};
                  end
               end
               state_in = ST_TICK_RD;
            end
         end
         ST_TICK_RD: state_in = (mode_ff == AMP_DIRECT) ? ST_TICK_MUL : ST_TICK_DIV;
         ST_TICK_DIV: begin
            if (!drsp.busy) begin
               if (mode_ff == AMP_DECAY) amp_in = 17'(q[16:0] + sus17);
               else amp_in = q[16:0];
               state_in = ST_TICK_MUL;
            end
         end
         ST_TICK_MUL: begin
            prod_in = wrd_ff * $signed({1'b0, amp_ff});
            sum = acc_ff + 40'(prod_in);
            acc_in = sum;
            if (v_ff == VIDX_BITS'(VOICES-1)) state_in = ST_TICK_ACC;
            else begin
               v_in = v_ff + 1'b1;
               state_in = ST_TICK_SEL;
            end
         end
         ST_TICK_ACC: begin
            qs = 24'(acc_ff >>> 16);
            if (qs > 24'sd524287) samp_in = 20'h7FFFF;
            else if (qs < -24'sd524288) samp_in = 20'h80000;
            else samp_in = qs[19:0];
            for (int i = 0; i < VOICES; i++) ph_in[i] = ph_ff[i] + st_ff[i];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_in = {7'd0, drop_ff, hc_ff, samp_ff};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         held_ff <= '0;
         hc_ff <= '0;
         for (int i = 0; i < VOICES; i++) begin
            al_ff[i] <= '0; dl_ff[i] <= '0; rl_ff[i] <= '0;
            ph_ff[i] <= '0; st_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff <= held_in;
         hc_ff <= hc_in;
         al_ff <= al_in; dl_ff <= dl_in; rl_ff <= rl_in;
         ph_ff <= ph_in; st_ff <= st_in;
      end
      cmd_ff <= cmd_in; step_ff <= step_in; tidx_ff <= tidx_in; tval_ff <= tval_in;
      v_ff <= v_in; pick_ff <= pick_in; matched_ff <= matched_in;
      acc_ff <= acc_in; amp_ff <= amp_in; mode_ff <= mode_in; prod_ff <= prod_in;
      out_ff <= out_in; drop_ff <= drop_in; samp_ff <= samp_in;
   end
endmodule
